FILE: rtl/core/plbd_pkg.sv
// ----------------------------------------------------------------------------
// plbd_pkg: shared definitions of the pulsed light barrier detector
// Widths, register indexes, the configuration bundle and the command that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package plbd_pkg;

  // Number of converter bits that take part in the measurement.
  localparam int unsigned SAMPLE_BITS = 10;

  localparam int unsigned SENSOR_W = 10;
  localparam int unsigned PULSE_W  = 8;
  localparam int unsigned TOL_W    = 7;
  localparam int unsigned CAL_W    = 16;
  localparam int unsigned SKIP_W   = 16;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned SUM_W    = CNT_W + SAMPLE_BITS;
  localparam int unsigned AVG_W    = SAMPLE_BITS + 1;
  localparam int unsigned CMP_W    = SAMPLE_BITS + TOL_W;
  localparam int unsigned DIV_CNT_W = $clog2(SAMPLE_BITS);

  localparam int unsigned PERCENT_SCALE = 100;

  localparam logic [PULSE_W-1:0] PULSE_RESET = 8'd5;
  localparam logic [TOL_W-1:0]   TOL_RESET   = 7'd10;
  localparam logic [CAL_W-1:0]   CAL_RESET   = 16'd500;

  // Command queue.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_PULSE_PERIOD = 2'd0;
  localparam logic [1:0] REG_TOLERANCE    = 2'd1;
  localparam logic [1:0] REG_CALIB_PERIOD = 2'd2;

  // Input request codes.
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SKIP = 1'b1;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_period;
    logic [TOL_W-1:0]   tolerance;
    logic [CAL_W-1:0]   calib_period;
  } plbd_cfg_t;

  typedef struct packed {
    logic                   calib_fire;
    logic                   pulse_edge;
    logic [SAMPLE_BITS-1:0] sample;
  } plbd_cmd_t;

endpackage

FILE: rtl/core/plbd_front.sv
// ----------------------------------------------------------------------------
// plbd_front: request intake and timing
// Accepts tick and skip requests, runs the calibration, pulse and skip timers
// and turns every request into one command for the back end.
// ----------------------------------------------------------------------------
module plbd_front
  import plbd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plbd_cfg_t           cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [SENSOR_W-1:0] sensor_sample_i,
  input  logic [SKIP_W-1:0]   skip_ms_i,
  output logic                push_o,
  output plbd_cmd_t           cmd_o,
  input  logic                full_i
);

  logic [PULSE_W-1:0] pulse_timer_q, pulse_timer_d;
  logic [CAL_W-1:0]   calib_timer_q, calib_timer_d;
  logic [SKIP_W-1:0]  skip_q, skip_d;
  logic [PULSE_W-1:0] pulse_period;
  logic [CAL_W-1:0]   calib_period;
  logic               accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  // A period of zero behaves as one.
  assign pulse_period = (cfg_i.pulse_period == '0) ? PULSE_W'(1) : cfg_i.pulse_period;
  assign calib_period = (cfg_i.calib_period == '0) ? CAL_W'(1) : cfg_i.calib_period;

  always_comb begin
    pulse_timer_d     = pulse_timer_q;
    calib_timer_d     = calib_timer_q;
    skip_d            = skip_q;
    cmd_o.calib_fire  = 1'b0;
    cmd_o.pulse_edge  = 1'b0;
    cmd_o.sample      = SAMPLE_BITS'(sensor_sample_i);
    if (req_type_i == REQ_SKIP) begin
      skip_d = skip_ms_i;
    end else begin
      if (calib_timer_q == '0) begin
        calib_timer_d    = calib_period - CAL_W'(1);
        cmd_o.calib_fire = 1'b1;
      end else begin
        calib_timer_d = calib_timer_q - CAL_W'(1);
      end
      if (pulse_timer_q == '0) begin
        pulse_timer_d = pulse_period - PULSE_W'(1);
        // While skipping, the edge is absorbed here and the laser is left alone.
        if (skip_q != '0) begin
          skip_d = (skip_q > SKIP_W'(cfg_i.pulse_period)) ?
                   skip_q - SKIP_W'(cfg_i.pulse_period) : '0;
        end else begin
          cmd_o.pulse_edge = 1'b1;
        end
      end else begin
        pulse_timer_d = pulse_timer_q - PULSE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_timer_q <= '0;
      calib_timer_q <= '0;
      skip_q        <= '0;
    end else if (accept) begin
      pulse_timer_q <= pulse_timer_d;
      calib_timer_q <= calib_timer_d;
      skip_q        <= skip_d;
    end
  end

endmodule

FILE: rtl/core/plbd_queue.sv
// ----------------------------------------------------------------------------
// plbd_queue: command queue
// Short first-in first-out buffer that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
module plbd_queue
  import plbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  plbd_cmd_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output plbd_cmd_t pop_data_o,
  output logic      empty_o
);

  plbd_cmd_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QPTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QPTR_W+1)'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

endmodule

FILE: rtl/core/plbd_back.sv
// ----------------------------------------------------------------------------
// plbd_back: measurement engine
// Executes commands: recomputes the averages with a serial divider, handles
// the laser pulse edge and the obstacle test, and holds the result register.
// ----------------------------------------------------------------------------
module plbd_back
  import plbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  plbd_cfg_t cfg_i,
  input  logic      empty_i,
  input  plbd_cmd_t cmd_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output logic      laser_drive_o,
  output logic      obstacle_seen_o,
  output logic      is_calibrated_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e                 state_q;
  plbd_cmd_t              cmd_q;

  logic                   laser_q;
  logic                   obstacle_q;
  logic                   calibrated_q;
  logic [SAMPLE_BITS-1:0] dark_sample_q;
  logic [SUM_W-1:0]       lit_sum_q;
  logic [SUM_W-1:0]       dark_sum_q;
  logic [CNT_W-1:0]       count_q;
  logic [SAMPLE_BITS-1:0] lit_avg_q;
  logic [AVG_W-1:0]       dark_avg_q;

  logic [SUM_W-1:0]       rem_lit_q, rem_dark_q, divisor_q;
  logic [SAMPLE_BITS-1:0] quo_lit_q, quo_dark_q;
  logic [DIV_CNT_W-1:0]   div_cnt_q;

  logic                   out_valid_q, out_laser_q, out_obstacle_q, out_cal_q;

  // Divider step.
  logic                   lit_ge, dark_ge;
  logic [SUM_W-1:0]       rem_lit_d, rem_dark_d;
  logic [SAMPLE_BITS-1:0] quo_lit_d, quo_dark_d;
  logic [SAMPLE_BITS-1:0] avg_diff;
  logic [CMP_W-1:0]       diff_scaled, tol_scaled;
  logic                   calibrated_d;

  // Pulse edge.
  logic [AVG_W-1:0]       sample_ext, lit_ext, lit_dist, dark_dist;
  logic                   beam_clear;
  logic                   laser_d, obstacle_d, accumulate, take_dark;
  logic                   exec_go;

  assign lit_ge     = (rem_lit_q >= divisor_q);
  assign dark_ge    = (rem_dark_q >= divisor_q);
  assign rem_lit_d  = lit_ge ? rem_lit_q - divisor_q : rem_lit_q;
  assign rem_dark_d = dark_ge ? rem_dark_q - divisor_q : rem_dark_q;
  assign quo_lit_d  = {quo_lit_q[SAMPLE_BITS-2:0], lit_ge};
  assign quo_dark_d = {quo_dark_q[SAMPLE_BITS-2:0], dark_ge};

  // Calibrated when 100 * (dark - lit) exceeds tolerance * full scale.
  assign avg_diff     = quo_dark_d - quo_lit_d;
  assign diff_scaled  = CMP_W'(avg_diff) * CMP_W'(PERCENT_SCALE);
  assign tol_scaled   = {cfg_i.tolerance, {SAMPLE_BITS{1'b0}}};
  assign calibrated_d = (quo_dark_d > quo_lit_d) && (diff_scaled > tol_scaled);

  assign sample_ext = AVG_W'(cmd_q.sample);
  assign lit_ext    = AVG_W'(lit_avg_q);
  assign lit_dist   = (lit_ext > sample_ext) ? lit_ext - sample_ext : sample_ext - lit_ext;
  assign dark_dist  = (dark_avg_q > sample_ext) ? dark_avg_q - sample_ext
                                                : sample_ext - dark_avg_q;
  assign beam_clear = !calibrated_q || (lit_dist < dark_dist);

  always_comb begin
    laser_d    = laser_q;
    obstacle_d = obstacle_q;
    accumulate = 1'b0;
    take_dark  = 1'b0;
    if (cmd_q.pulse_edge) begin
      if (laser_q) begin
        laser_d = 1'b0;
        if (beam_clear) begin
          obstacle_d = 1'b0;
          accumulate = (count_q != '1);
        end else begin
          obstacle_d = 1'b1;
        end
      end else begin
        laser_d   = 1'b1;
        take_dark = 1'b1;
      end
    end
  end

  assign exec_go = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign pop_o   = (state_q == S_IDLE) && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      laser_q       <= 1'b0;
      obstacle_q    <= 1'b0;
      calibrated_q  <= 1'b0;
      dark_sample_q <= '0;
      lit_sum_q     <= '0;
      dark_sum_q    <= '0;
      count_q       <= '0;
      lit_avg_q     <= '0;
      dark_avg_q    <= AVG_W'(1) << SAMPLE_BITS;
      div_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            if (cmd_i.calib_fire && (count_q != '0)) begin
              div_cnt_q <= DIV_CNT_W'(SAMPLE_BITS - 1);
              state_q   <= S_DIV;
            end else begin
              state_q <= S_EXEC;
            end
          end
        end
        S_DIV: begin
          div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
          if (div_cnt_q == '0) begin
            lit_avg_q    <= quo_lit_d;
            dark_avg_q   <= AVG_W'(quo_dark_d);
            calibrated_q <= calibrated_d;
            lit_sum_q    <= '0;
            dark_sum_q   <= '0;
            count_q      <= '0;
            state_q      <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            laser_q    <= laser_d;
            obstacle_q <= obstacle_d;
            if (take_dark) begin
              dark_sample_q <= cmd_q.sample;
            end
            if (accumulate) begin
              lit_sum_q  <= lit_sum_q + SUM_W'(cmd_q.sample);
              dark_sum_q <= dark_sum_q + SUM_W'(dark_sample_q);
              count_q    <= count_q + CNT_W'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q      <= cmd_i;
      rem_lit_q  <= lit_sum_q;
      rem_dark_q <= dark_sum_q;
      divisor_q  <= SUM_W'(count_q) << (SAMPLE_BITS - 1);
    end else if (state_q == S_DIV) begin
      rem_lit_q  <= rem_lit_d;
      rem_dark_q <= rem_dark_d;
      divisor_q  <= divisor_q >> 1;
      quo_lit_q  <= quo_lit_d;
      quo_dark_q <= quo_dark_d;
    end
    if (exec_go) begin
      out_laser_q    <= laser_d;
      out_obstacle_q <= obstacle_d;
      out_cal_q      <= calibrated_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign laser_drive_o   = out_laser_q;
  assign obstacle_seen_o = out_obstacle_q;
  assign is_calibrated_o = out_cal_q;

  a_div_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (count_q != '0))
    else $error("divider running with an empty sample count");

  a_div_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_cnt_q < DIV_CNT_W'(SAMPLE_BITS)))
    else $error("divider step counter out of range");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_go |=> (state_q == S_IDLE) && out_valid_q)
    else $error("executed command did not produce a result");

endmodule

FILE: rtl/core/pulsed_light_barrier_detector_unit.sv
// ----------------------------------------------------------------------------
// pulsed_light_barrier_detector_unit: pulsed light barrier detector
// Top level: APB register file, request front end, command queue and
// measurement back end.
// ----------------------------------------------------------------------------
// Usage. The input channel carries one transaction per request: a tick
// (req_type_i = 0) stands for one millisecond and brings a sensor sample,
// a skip request (req_type_i = 1) loads the blanking time skip_ms_i. Every
// accepted transaction produces exactly one result transaction on the output
// channel with the laser level, the obstacle flag and the calibration flag
// as they stand after that request.
// A result reaches out_valid_o once its request has passed the queue, the
// idle and execute states of the back end and the result register. A tick
// on which the calibration timer fires with samples pending also passes the
// serial divider that recomputes both averages. The back end works on one
// request at a time and takes the next only once the current one is done.
// A four-entry command queue lets requests be accepted while the back end
// is busy; in_stall_o is high only when that queue is full.
// When out_stall_i is high the result register holds its transaction and
// the back end waits with the next one, while the queue keeps filling.
// Reset clears all timers, sums and flags: the first tick fires both timers,
// the laser starts off and the barrier starts uncalibrated. The configuration
// registers return to their reset values. Registers are to be written over
// APB only while the block is idle, unenforced by it; pready is always high.
// ----------------------------------------------------------------------------
module pulsed_light_barrier_detector_unit
  import plbd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // Request channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                req_type_i,
  input  logic [SENSOR_W-1:0] sensor_sample_i,
  input  logic [SKIP_W-1:0]   skip_ms_i,
  // Result channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                laser_drive_o,
  output logic                obstacle_seen_o,
  output logic                is_calibrated_o
);

  plbd_cfg_t cfg_q;
  logic      cfg_write;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;
  plbd_cmd_t push_cmd;
  plbd_cmd_t pop_cmd;

  // The register file answers every access at once.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_period <= PULSE_RESET;
      cfg_q.tolerance    <= TOL_RESET;
      cfg_q.calib_period <= CAL_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_PULSE_PERIOD: cfg_q.pulse_period <= pwdata[PULSE_W-1:0];
        REG_TOLERANCE:    cfg_q.tolerance    <= pwdata[TOL_W-1:0];
        REG_CALIB_PERIOD: cfg_q.calib_period <= pwdata[CAL_W-1:0];
        default: begin
          // Addresses beyond the register list are ignored.
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PULSE_PERIOD: prdata = 32'(cfg_q.pulse_period);
      REG_TOLERANCE:    prdata = 32'(cfg_q.tolerance);
      REG_CALIB_PERIOD: prdata = 32'(cfg_q.calib_period);
      default:          prdata = '0;
    endcase
  end

  // The front end runs the timers and classifies each request.
  plbd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .sensor_sample_i (sensor_sample_i),
    .skip_ms_i       (skip_ms_i),
    .push_o          (push),
    .cmd_o           (push_cmd),
    .full_i          (full)
  );

  plbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (empty)
  );

  // The back end owns the measurement state and the result register.
  plbd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .empty_i         (empty),
    .cmd_i           (pop_cmd),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .laser_drive_o   (laser_drive_o),
    .obstacle_seen_o (obstacle_seen_o),
    .is_calibrated_o (is_calibrated_o)
  );

endmodule

FILE: test/plbd_beam_checker.sv
// ----------------------------------------------------------------------------
// plbd_beam_checker: result checker of the pulsed light barrier detector
// Follows the register writes and the accepted requests, works out the
// laser, obstacle and calibration flags that each request leaves behind,
// and compares every accepted result transaction with the oldest of them.
// ----------------------------------------------------------------------------
module plbd_beam_checker
  import plbd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration port, observed only.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  // Request channel.
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                req_type_i,
  input  logic [SENSOR_W-1:0] sensor_sample_i,
  input  logic [SKIP_W-1:0]   skip_ms_i,
  // Result channel.
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                laser_drive_i,
  input  logic                obstacle_seen_i,
  input  logic                is_calibrated_i,
  // Status for the testbench top.
  output int unsigned         mismatches_o,
  output int unsigned         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FULL_SCALE = 1 << SAMPLE_BITS;

  typedef struct packed {
    logic laser;
    logic obstacle;
    logic calibrated;
  } beam_status_t;

  beam_status_t beam_status_q[$];
  int unsigned  mismatches;

  // Register copies.
  logic [PULSE_W-1:0] pulse_period;
  logic [TOL_W-1:0]   tolerance;
  logic [CAL_W-1:0]   calib_period;

  // Detector state.
  logic                   laser_on;
  logic [PULSE_W-1:0]     pulse_cnt;
  logic [CAL_W-1:0]       calib_cnt;
  logic [SKIP_W-1:0]      skip_left;
  logic [SAMPLE_BITS-1:0] last_dark;
  logic [SUM_W-1:0]       lit_acc;
  logic [SUM_W-1:0]       dark_acc;
  logic [CNT_W-1:0]       clear_count;
  logic [AVG_W-1:0]       lit_avg;
  logic [AVG_W-1:0]       dark_avg;
  logic                   calibrated;
  logic                   blocked;

  task automatic refresh_averages();
    int diff;
    if (clear_count != '0) begin
      lit_avg     = {1'b0, SAMPLE_BITS'(lit_acc / clear_count)};
      dark_avg    = {1'b0, SAMPLE_BITS'(dark_acc / clear_count)};
      lit_acc     = '0;
      dark_acc    = '0;
      clear_count = '0;
      diff        = int'(dark_avg) - int'(lit_avg);
      calibrated  = (diff != FULL_SCALE) &&
                    (int'(PERCENT_SCALE) * diff > int'(tolerance) * FULL_SCALE);
    end
  endtask

  task automatic take_pulse_edge(input logic [SAMPLE_BITS-1:0] s);
    int to_lit;
    int to_dark;
    if (skip_left != '0) begin
      // Blanking: the laser keeps its level while the skip time runs out.
      if (skip_left > pulse_period) skip_left = skip_left - pulse_period;
      else skip_left = '0;
    end else if (laser_on) begin
      laser_on = 1'b0;
      to_lit   = int'(lit_avg) - int'(s);
      to_dark  = int'(dark_avg) - int'(s);
      if (to_lit < 0) to_lit = -to_lit;
      if (to_dark < 0) to_dark = -to_dark;
      if (!calibrated || to_lit < to_dark) begin
        if (clear_count != '1) begin
          lit_acc     = lit_acc + s;
          dark_acc    = dark_acc + last_dark;
          clear_count = clear_count + 1'b1;
        end
        blocked = 1'b0;
      end else begin
        blocked = 1'b1;
      end
    end else begin
      last_dark = s;
      laser_on  = 1'b1;
    end
  endtask

  task automatic predict_beam_status(input logic kind, input logic [SENSOR_W-1:0] sample,
                                     input logic [SKIP_W-1:0] skip);
    logic [CAL_W-1:0]   calib_reload;
    logic [PULSE_W-1:0] pulse_reload;
    beam_status_t       status;
    if (kind == REQ_SKIP) begin
      skip_left = skip;
    end else begin
      // A zero period behaves like a period of one.
      calib_reload = (calib_period == '0) ? CAL_W'(1) : calib_period;
      pulse_reload = (pulse_period == '0) ? PULSE_W'(1) : pulse_period;
      if (calib_cnt == '0) begin
        calib_cnt = calib_reload - 1'b1;
        refresh_averages();
      end else begin
        calib_cnt = calib_cnt - 1'b1;
      end
      if (pulse_cnt == '0) begin
        pulse_cnt = pulse_reload - 1'b1;
        take_pulse_edge(sample[SAMPLE_BITS-1:0]);
      end else begin
        pulse_cnt = pulse_cnt - 1'b1;
      end
    end
    status.laser      = laser_on;
    status.obstacle   = blocked;
    status.calibrated = calibrated;
    beam_status_q.push_back(status);
  endtask

  task automatic check_field(input string field, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beam_status_t want;
    if (!rst_ni) begin
      pulse_period = PULSE_RESET;
      tolerance    = TOL_RESET;
      calib_period = CAL_RESET;
      laser_on     = 1'b0;
      pulse_cnt    = '0;
      calib_cnt    = '0;
      skip_left    = '0;
      last_dark    = '0;
      lit_acc      = '0;
      dark_acc     = '0;
      clear_count  = '0;
      lit_avg      = '0;
      dark_avg     = AVG_W'(FULL_SCALE);
      calibrated   = 1'b0;
      blocked      = 1'b0;
      mismatches   = 0;
      beam_status_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_PULSE_PERIOD: pulse_period = pwdata[PULSE_W-1:0];
          REG_TOLERANCE:    tolerance    = pwdata[TOL_W-1:0];
          REG_CALIB_PERIOD: calib_period = pwdata[CAL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (beam_status_q.size() == 0) begin
          $error("result transaction with nothing expected: laser %0d obstacle %0d cal %0d",
                 laser_drive_i, obstacle_seen_i, is_calibrated_i);
          mismatches++;
        end else begin
          want = beam_status_q.pop_front();
          check_field("laser_drive", want.laser, laser_drive_i);
          check_field("obstacle_seen", want.obstacle, obstacle_seen_i);
          check_field("is_calibrated", want.calibrated, is_calibrated_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_beam_status(req_type_i, sensor_sample_i, skip_ms_i);
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= beam_status_q.size();
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the pulsed light barrier detector
// Drives directed and random requests through the request channel, changes
// the registers over APB between phases and lets the checker compare every
// result transaction. Both channels pause and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plbd_pkg::*;

  // Cycles without any transaction or register access before giving up. The
  // slowest legal stretch is a sender gap plus a receiver stall plus one
  // recompute in the back end.
  localparam int unsigned QUIET_LIMIT = 2000;
  // Cycles spent after the last result before the verdict.
  localparam int unsigned TAIL_CYCLES = 40;
  // Items per random phase.
  localparam int unsigned PHASE_ITEMS = 300;
  // The address slot above the three registers; writes there are dropped.
  localparam logic [1:0]  REG_SPARE = 2'd3;

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [3:0]          paddr           = '0;
  logic [31:0]         pwdata          = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic                req_type_i      = REQ_TICK;
  logic [SENSOR_W-1:0] sensor_sample_i = '0;
  logic [SKIP_W-1:0]   skip_ms_i       = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic                laser_drive_o;
  logic                obstacle_seen_o;
  logic                is_calibrated_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent   = 0;
  // While set, neither side inserts any pause.
  bit          calm         = 1'b0;
  // Pulse period currently programmed; shapes the light pattern of a scene.
  int unsigned pulse_cfg    = 32'(PULSE_RESET);

  // Register settings of the random phases; the last one is drawn at random.
  int unsigned pulse_set[6] = '{1, 2, 255, 0, 1, 1};
  int unsigned tol_set[6]   = '{10, 0, 100, 5, 127, 10};
  int unsigned calib_set[6] = '{16, 40, 65535, 0, 8, 16};

  pulsed_light_barrier_detector_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .sensor_sample_i(sensor_sample_i),
    .skip_ms_i      (skip_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .laser_drive_o  (laser_drive_o),
    .obstacle_seen_o(obstacle_seen_o),
    .is_calibrated_o(is_calibrated_o)
  );

  // The checker sits beside the block and sees exactly what the block sees.
  plbd_beam_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .req_type_i     (req_type_i),
    .sensor_sample_i(sensor_sample_i),
    .skip_ms_i      (skip_ms_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .laser_drive_i  (laser_drive_o),
    .obstacle_seen_i(obstacle_seen_o),
    .is_calibrated_i(is_calibrated_o),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: any transaction or register access counts as progress. A run
  // that sits still for too long has hung somewhere.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Number of idle cycles before the next transaction on either side.
  function automatic int unsigned pause_len();
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // Keeps a level inside the converter range after adding a little noise.
  function automatic int unsigned near(input int unsigned level);
    int v;
    v = int'(level) + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  // Result side: stalls for a random number of cycles, then takes one
  // transaction. The stall is drawn whether or not a result is waiting, so
  // it lands on every phase of the back end's work.
  initial begin : result_sink
    int unsigned hold;
    forever begin
      hold = pause_len();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offers one request transaction after a random gap and waits until the
  // block takes it. Valid stays high across back-to-back transactions, and
  // the payload only changes once the previous one has been accepted.
  task automatic send(input logic kind, input int unsigned sample, input int unsigned skip_len);
    int unsigned gap;
    gap = pause_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= kind;
    sensor_sample_i <= SENSOR_W'(sample);
    skip_ms_i       <= SKIP_W'(skip_len);
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // A tick carries a sample; its skip field is don't-care, so it gets noise.
  task automatic tick(input int unsigned sample);
    send(REQ_TICK, sample, $urandom_range(0, 65535));
  endtask

  task automatic skip(input int unsigned ms);
    send(REQ_SKIP, $urandom_range(0, 1023), ms);
  endtask

  // Stops offering requests until every expected result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // One APB write: setup cycle, access cycle, then an idle cycle so that
  // back-to-back writes never assign psel twice in one time step.
  task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers only change while the block is idle.
  task automatic set_config(input int unsigned pulse, input int unsigned tol,
                            input int unsigned calib);
    drain();
    apb_write(REG_PULSE_PERIOD, pulse);
    apb_write(REG_TOLERANCE, tol);
    apb_write(REG_CALIB_PERIOD, calib);
    pulse_cfg = pulse;
  endtask

  // A well-formed stretch of ticks: the sensor reads a dark level while the
  // laser is off and a lit level while it is on, following the pulse period.
  // The testbench does not know the block's pulse phase, so the pattern
  // starts on a random phase; a wrong guess gives an inverted, uncalibrated
  // barrier, which is worth covering too. Now and then the beam is blocked
  // and a lit reading looks dark, which is how obstacles are reported.
  task automatic run_scene(input int unsigned ticks);
    int unsigned dark_lvl;
    int unsigned lit_lvl;
    int unsigned span;
    int unsigned k;
    bit          lit_first;
    bit          lit_now;
    dark_lvl = $urandom_range(600, 1023);
    lit_lvl  = $urandom_range(0, 420);
    if ($urandom_range(0, 4) == 0) begin
      dark_lvl = $urandom_range(0, 1023);
      lit_lvl  = $urandom_range(0, 1023);
    end
    span      = (pulse_cfg == 0) ? 1 : pulse_cfg;
    lit_first = $urandom_range(0, 1);
    for (k = 0; k < ticks; k++) begin
      lit_now = lit_first ^ ((k / span) % 2);
      if (lit_now && $urandom_range(0, 4) == 0) tick(near(dark_lvl));
      else tick(near(lit_now ? lit_lvl : dark_lvl));
    end
  endtask

  // Unstructured traffic: arbitrary samples, short skips, and now and then
  // a long skip that is cut short again by the next request.
  task automatic noise_item();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      tick($urandom_range(0, 1023));
    end else if (pick < 17) begin
      skip($urandom_range(0, 12));
    end else begin
      skip($urandom_range(0, 65535));
      skip($urandom_range(0, 3));
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_start;
    int unsigned k;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset register values first: full-scale and zero
    // samples, the longest skip, and a skip of zero that ends the blanking.
    tick(1023);
    tick(0);
    skip(65535);
    tick(512);
    skip(0);
    tick(1023);
    tick(0);
    tick(1);

    // Zero periods make both timers fire on every tick, and a tolerance
    // above 100 percent can never be met. A zero pulse period also leaves a
    // pending skip stuck until a new skip request replaces it. The write to
    // the spare address must not disturb anything.
    set_config(0, 127, 0);
    apb_write(REG_SPARE, 32'hFFFF_FFFF);
    tick(1023);
    tick(0);
    tick(1023);
    skip(7);
    tick(5);
    tick(1000);
    skip(0);
    tick(0);

    // Zero tolerance and short periods: a clean dark/lit pattern calibrates
    // quickly, then a lit reading near the dark level shows as an obstacle.
    set_config(1, 0, 4);
    for (k = 0; k < 8; k++) tick((k % 2 == 0) ? 1000 : 20);
    tick(1000);
    tick(990);

    // Random phases, each with its own register setting.
    for (phase = 0; phase < 6; phase++) begin
      if (phase == 5) begin
        set_config($urandom_range(1, 4), $urandom_range(0, 40), $urandom_range(1, 64));
      end else begin
        set_config(pulse_set[phase], tol_set[phase], calib_set[phase]);
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) != 0) run_scene($urandom_range(10, 50));
        else noise_item();
        // Occasionally let the pipeline run dry in the middle of a phase.
        if ($urandom_range(0, 29) == 0) drain();
      end
      calm = 1'b0;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
